FILE: hdl/pn_pkg.sv
// Package with the shared constants, codes and types of the path normaliser.
`default_nettype none
package pn_pkg;

    localparam int PATH_DEPTH     = 64;
    localparam int MAX_COMPONENTS = 32;
    localparam int PATH_AW        = $clog2(PATH_DEPTH);
    localparam int LEN_W          = $clog2(PATH_DEPTH + 1);
    localparam int COMP_AW        = $clog2(MAX_COMPONENTS);
    localparam int COUNT_W        = $clog2(MAX_COMPONENTS + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SLASH = 8'h2F;
    localparam logic [7:0] DOT   = 8'h2E;

    localparam logic [1:0] FUNC_CHAR  = 2'd0;
    localparam logic [1:0] FUNC_END   = 2'd1;
    localparam logic [1:0] FUNC_PRINT = 2'd2;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_END,
        OP_PRINT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic       is_slash;
        logic       is_dot;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NAME_PUT,
        ST_POP_DIR,
        ST_PRINT_RD,
        ST_PRINT_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/pn_front.sv
// Front end: decodes incoming requests into queued commands.
`default_nettype none
module pn_front (
    input  wire logic        [1:0] func,
    input  wire logic        [7:0] in_char,
    input  wire logic              in_fire,
    output logic                   push,
    output pn_pkg::cmd_t           cmd
);
    import pn_pkg::*;

    always_comb begin
        cmd.ch       = in_char;
        cmd.is_slash = (in_char == SLASH);
        cmd.is_dot   = (in_char == DOT);
        cmd.op       = OP_CHAR;
        push         = 1'b0;
        unique case (func)
            FUNC_CHAR: begin
                cmd.op = OP_CHAR;
                push   = in_fire;
            end
            FUNC_END: begin
                cmd.op = OP_END;
                push   = in_fire;
            end
            FUNC_PRINT: begin
                cmd.op = OP_PRINT;
                push   = in_fire;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/pn_queue.sv
// Small command queue between the front end and the back end.
`default_nettype none
module pn_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire pn_pkg::cmd_t push_cmd,
    output logic              full,
    input  wire logic         pop,
    output pn_pkg::cmd_t      pop_cmd,
    output logic              empty
);
    import pn_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full    = (fill_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + QUEUE_AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QUEUE_AW'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + QUEUE_CW'(1);
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pn_back.sv
// Back end: applies queued commands to the stored path and streams it out.
`default_nettype none
module pn_back (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire pn_pkg::cmd_t cmd,
    input  wire logic         cmd_empty,
    output logic              cmd_pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic        [7:0] m_char,
    output logic              m_last,
    output logic              m_ovf
);
    import pn_pkg::*;

    logic [7:0]         path_mem   [PATH_DEPTH];
    logic [PATH_AW-1:0] starts_mem [MAX_COMPONENTS];

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         dot_run_reg, dot_run_next;
    logic [1:0]         dots_left_reg, dots_left_next;
    logic               at_start_reg, at_start_next;
    logic               has_name_reg, has_name_next;
    logic               dropped_reg, dropped_next;
    logic               ovf_reg, ovf_next;
    logic [7:0]         hold_char_reg, hold_char_next;
    logic [PATH_AW-1:0] idx_reg, idx_next;
    logic [7:0]         out_char_reg;
    logic               out_last_reg;
    logic [PATH_AW-1:0] starts_rd_reg;

    logic               path_we;
    logic [7:0]         path_wdata;
    logic               starts_we;
    logic               put_req;
    logic [7:0]         put_data;
    logic               close_req;
    logic [COMP_AW-1:0] starts_raddr;
    logic [COUNT_W-1:0] count_dec;

    assign count_dec    = count_reg - COUNT_W'(1);
    assign starts_raddr = count_dec[COMP_AW-1:0];
    assign m_valid      = (state_reg == ST_PRINT_OUT);
    assign m_char       = out_char_reg;
    assign m_last       = out_last_reg;
    assign m_ovf        = ovf_reg;

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        dot_run_next   = dot_run_reg;
        dots_left_next = dots_left_reg;
        at_start_next  = at_start_reg;
        has_name_next  = has_name_reg;
        dropped_next   = dropped_reg;
        ovf_next       = ovf_reg;
        hold_char_next = hold_char_reg;
        idx_next       = idx_reg;
        cmd_pop        = 1'b0;
        path_we        = 1'b0;
        path_wdata     = SLASH;
        starts_we      = 1'b0;
        put_req        = 1'b0;
        put_data       = hold_char_reg;
        close_req      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_CHAR: begin
                            at_start_next = 1'b0;
                            if (at_start_reg && cmd.is_slash) begin
                                len_next      = LEN_W'(1);
                                count_next    = '0;
                                dot_run_next  = '0;
                                has_name_next = 1'b0;
                                dropped_next  = 1'b0;
                            end else if (cmd.is_slash) begin
                                close_req = 1'b1;
                            end else if (cmd.is_dot && !has_name_reg &&
                                         dot_run_reg < 2'd2) begin
                                dot_run_next = dot_run_reg + 2'd1;
                            end else if (!has_name_reg) begin
                                has_name_next = 1'b1;
                                if (count_reg >= COUNT_W'(MAX_COMPONENTS) ||
                                    len_reg > LEN_W'(PATH_DEPTH - 2)) begin
                                    dropped_next = 1'b1;
                                    ovf_next     = 1'b1;
                                end else begin
                                    starts_we  = 1'b1;
                                    count_next = count_reg + COUNT_W'(1);
                                end
                                dots_left_next = dot_run_reg;
                                dot_run_next   = '0;
                                hold_char_next = cmd.ch;
                                state_next     = ST_NAME_PUT;
                            end else begin
                                put_req  = 1'b1;
                                put_data = cmd.ch;
                            end
                        end
                        OP_END: begin
                            close_req     = 1'b1;
                            at_start_next = 1'b1;
                        end
                        OP_PRINT: begin
                            idx_next   = '0;
                            state_next = ST_PRINT_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NAME_PUT: begin
                put_req = 1'b1;
                if (dots_left_reg != 2'd0) begin
                    put_data       = DOT;
                    dots_left_next = dots_left_reg - 2'd1;
                end else begin
                    put_data   = hold_char_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_POP_DIR: begin
                count_next = count_dec;
                if (starts_rd_reg == '0) begin
                    len_next = LEN_W'(1);
                end else begin
                    len_next = LEN_W'(starts_rd_reg);
                end
                state_next = ST_IDLE;
            end
            ST_PRINT_RD: begin
                state_next = ST_PRINT_OUT;
            end
            ST_PRINT_OUT: begin
                if (m_ready) begin
                    if (out_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + PATH_AW'(1);
                        state_next = ST_PRINT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A segment closes: a name gets its trailing slash, a ".." climbs one level.
        if (close_req) begin
            if (has_name_reg) begin
                if (!dropped_reg && len_reg < LEN_W'(PATH_DEPTH)) begin
                    path_we    = 1'b1;
                    path_wdata = SLASH;
                    len_next   = len_reg + LEN_W'(1);
                end
            end else if (dot_run_reg == 2'd2 && count_reg != '0) begin
                state_next = ST_POP_DIR;
            end
            dot_run_next  = '0;
            has_name_next = 1'b0;
            dropped_next  = 1'b0;
        end

        if (put_req && !dropped_reg) begin
            if (len_reg < LEN_W'(PATH_DEPTH - 1)) begin
                path_we    = 1'b1;
                path_wdata = put_data;
                len_next   = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_W'(1);
            count_reg     <= '0;
            dot_run_reg   <= '0;
            dots_left_reg <= '0;
            at_start_reg  <= 1'b1;
            has_name_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            dot_run_reg   <= dot_run_next;
            dots_left_reg <= dots_left_next;
            at_start_reg  <= at_start_next;
            has_name_reg  <= has_name_next;
            dropped_reg   <= dropped_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_char_reg <= hold_char_next;
    end

    // Entry zero is never written; a read of index zero returns the root slash instead.
    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[len_reg[PATH_AW-1:0]] <= path_wdata;
        end
        if (state_reg == ST_PRINT_RD) begin
            out_char_reg <= (idx_reg == '0) ? SLASH : path_mem[idx_reg];
            out_last_reg <= ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (starts_we) begin
            starts_mem[count_reg[COMP_AW-1:0]] <= len_reg[PATH_AW-1:0];
        end
        starts_rd_reg <= starts_mem[starts_raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/path_normalizer.sv
// Path normaliser: keeps a current directory and applies change-directory requests.
//
// Input channel s_*: one request per handshake, func on s_tuser and the argument byte
// on s_tdata. func 0 carries one argument byte, func 1 closes a change-directory
// argument, func 2 asks for the path to be printed; func 3 is accepted and ignored.
// Only print requests produce output.
// Output channel m_*: one path byte per handshake, m_tlast on the final byte and
// m_tuser carrying the sticky overflow flag.
// Requests enter a four-deep queue, so s_tready stays high while the queue has room,
// also while a printed byte waits on a stalled receiver.
// The back end takes one queued request per cycle when it is idle. A byte that opens
// a name is written in ST_NAME_PUT after each leading dot it carries (up to two); a
// ".." closing passes through ST_POP_DIR, as it reads the component start table. A
// print reads each path byte in ST_PRINT_RD by the registered read of the path memory
// and presents it from the output register in ST_PRINT_OUT. When the receiver stalls,
// the byte is held in the output register and the back end waits; the queue keeps
// accepting until full.
// After reset the path is "/", the overflow flag is clear and no output is pending.
// No memory clearing pass is needed.
`default_nettype none
module path_normalizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_char [7:0]
    input  wire logic [1:0]  s_tuser,   // func [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // out_char [7:0]
    output logic             m_tlast,
    output logic      [0:0]  m_tuser    // overflow [0]
);
    import pn_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push, full, pop, empty;
    logic ovf;

    assign s_tready = !full;
    assign m_tuser  = ovf;

    pn_front u_front (
        .func    (s_tuser),
        .in_char (s_tdata),
        .in_fire (s_tvalid && s_tready),
        .push    (push),
        .cmd     (push_cmd)
    );

    pn_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    pn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (pop_cmd),
        .cmd_empty (empty),
        .cmd_pop   (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_char    (m_tdata),
        .m_last    (m_tlast),
        .m_ovf     (ovf)
    );

endmodule
`default_nettype wire

FILE: hdl/pn_checker.sv
// Port checker for the path normaliser, bound to the top level.
`default_nettype none
module pn_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic [0:0]  m_tuser
);
    import pn_pkg::*;

    logic mid_reg;
    logic ovf_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg      <= 1'b0;
            ovf_seen_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                mid_reg <= !m_tlast;
            end
            if (m_tvalid && m_tuser[0]) begin
                ovf_seen_reg <= 1'b1;
            end
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    a_root_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !mid_reg |-> m_tdata == SLASH)
        else $error("printed path does not start at the root");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ovf_seen_reg |-> m_tuser[0])
        else $error("overflow flag cleared");

endmodule

bind path_normalizer pn_checker u_pn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
